// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL core.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHK_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHK_ALWAYS(label, clk, rst_n, expr, msg)
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/gsfms_pkg.sv =====
`default_nettype none

package gsfms_pkg;

    localparam int COORD_W = 11;
    localparam int STEP_W  = 8;
    localparam int BRI_W   = 7;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 11;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_GRID_STEP    = 2'd2
    } t_cfg_idx;

    localparam logic [COORD_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [STEP_W-1:0]  STEP_RST   = 8'd40;

    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic        frame_start;
        logic        compare_frame;
    } t_pix_in;

    typedef struct packed {
        logic [SUM_W-1:0] motion_sum;
        logic [CNT_W-1:0] sample_count;
    } t_motion_out;

    // Red, the upper five green bits and blue, added: 0 to 93.
    function automatic logic [BRI_W-1:0] pix_brightness(input logic [15:0] pix);
        logic [BRI_W-1:0] r5;
        logic [BRI_W-1:0] g5;
        logic [BRI_W-1:0] b5;
        r5 = {2'b00, pix[15:11]};
        g5 = {2'b00, pix[10:6]};
        b5 = {2'b00, pix[4:0]};
        return r5 + g5 + b5;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gsfms_ram.sv =====
`default_nettype none

module gsfms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/grid_sampled_frame_motion_sum_core.sv =====
// Grid-sampled frame motion sum.
// Pixels enter as RGB565 words in raster order on the input channel
// (i_in_valid / o_in_stall / i_in_data); frame_start marks the first pixel of
// a frame. At each grid point the brightness of a reference frame is stored
// in a block RAM, and in a compare frame the absolute differences to the
// stored values are summed. The last pixel of a compare frame produces one
// word on the output channel (o_out_valid / i_out_stall / o_out_data) with
// the sum and the number of grid points taken in the frame.
// One pixel is taken every cycle while o_in_stall is low. The result passes
// from the RAM read and stage 1 through the output register. The RAM read
// port and the accumulator form a two-stage pipeline.
// While the receiver stalls, a waiting result holds and pixels keep flowing
// until a second result is ready behind it; then o_in_stall rises.
// Reset restores 640 x 480 with a step of 40 and clears position and sum.
// The RAM is not cleared; each compare frame must follow a reference frame.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
`default_nettype none
`include "assert_macros.svh"

module grid_sampled_frame_motion_sum_core
    import gsfms_pkg::*;
#(
    parameter int MAX_SAMPLES = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_pix_in            i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_motion_out             o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    localparam int IW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [IW-1:0] IDX_MAX = IW'(MAX_SAMPLES);

    // Configuration
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic [STEP_W-1:0]  r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_step   <= STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                CFG_GRID_STEP:    r_step   <= i_cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Position tracking, stage 0
    logic [COORD_W-1:0] r_col, r_row;
    logic [STEP_W:0]    r_cph;
    logic [STEP_W-1:0]  r_rph;
    logic               r_par;
    logic [IW-1:0]      r_idx;

    logic [COORD_W-1:0] c_col, c_row;
    logic [STEP_W:0]    c_cph;
    logic [STEP_W-1:0]  c_rph;
    logic               c_par;
    logic [IW-1:0]      c_idx;

    logic [COORD_W-1:0] n_col, n_row;
    logic [STEP_W:0]    n_cph;
    logic [STEP_W-1:0]  n_rph;
    logic               n_par;
    logic [IW-1:0]      n_idx;

    logic             s0_sample, s0_take, s0_row_end, s0_last;
    logic [BRI_W-1:0] s0_bri;
    logic             in_acc;

    always_comb begin
        c_col = i_in_data.frame_start ? '0 : r_col;
        c_row = i_in_data.frame_start ? '0 : r_row;
        c_cph = i_in_data.frame_start ? '0 : r_cph;
        c_rph = i_in_data.frame_start ? '0 : r_rph;
        c_par = i_in_data.frame_start ? 1'b0 : r_par;
        c_idx = i_in_data.frame_start ? '0 : r_idx;

        s0_sample = (r_step != '0) && (c_rph == '0) && (c_row != '0)
                  && (({1'b0, c_row} + {4'd0, r_step}) <= {1'b0, r_height})
                  && (c_col < r_width)
                  && (c_par ? (c_cph == {1'b0, r_step})
                            : ((c_cph == '0) && (c_col != '0)));
        s0_take = s0_sample && (c_idx < IDX_MAX);
        s0_bri  = pix_brightness(i_in_data.pixel_rgb565);

        s0_row_end = ({1'b0, c_col} + 12'd1) >= {1'b0, r_width};
        s0_last    = s0_row_end && (({1'b0, c_row} + 12'd1) >= {1'b0, r_height});

        n_col = c_col;
        n_row = c_row;
        n_cph = c_cph;
        n_rph = c_rph;
        n_par = c_par;
        n_idx = c_idx + IW'(s0_take);
        if (s0_last) begin
            n_col = '0;
            n_row = '0;
            n_cph = '0;
            n_rph = '0;
            n_par = 1'b0;
            n_idx = '0;
        end else if (s0_row_end) begin
            n_col = '0;
            n_cph = '0;
            n_row = c_row + 11'd1;
            if (({1'b0, c_rph} + 9'd1) >= {1'b0, r_step}) begin
                n_rph = '0;
                n_par = ~c_par;
            end else begin
                n_rph = c_rph + 8'd1;
            end
        end else begin
            n_col = c_col + 11'd1;
            n_cph = (({1'b0, c_cph} + 10'd1) >= {1'b0, r_step, 1'b0}) ? '0 : c_cph + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cph <= '0;
            r_rph <= '0;
            r_par <= 1'b0;
            r_idx <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_cph <= n_cph;
            r_rph <= n_rph;
            r_par <= n_par;
            r_idx <= n_idx;
        end
    end

    // Reference store. A slot is written once per frame, and a read of the
    // same slot can only come from a later pixel, so no forwarding is needed.
    logic [BRI_W-1:0] ram_q;

    gsfms_ram #(
        .WIDTH (BRI_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && s0_take && !i_in_data.compare_frame),
        .i_waddr (c_idx[AW-1:0]),
        .i_wdata (s0_bri),
        .i_re    (in_acc),
        .i_raddr (c_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    // Stage 1: difference and accumulate
    logic             r_s1_vld;
    logic             r_s1_cmp_take;
    logic             r_s1_start;
    logic             r_s1_last;
    logic             r_s1_emit;
    logic [BRI_W-1:0] r_s1_bri;
    logic [CNT_W-1:0] r_s1_cnt;
    logic [SUM_W-1:0] r_sum;

    logic             out_free, s1_free, s1_retire;
    logic [BRI_W-1:0] s1_diff;
    logic [SUM_W-1:0] s1_sum;

    logic             r_out_vld;
    t_motion_out      r_out;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_free    = !r_s1_vld || !r_s1_emit || out_free;
    assign s1_retire  = r_s1_vld && s1_free;
    assign in_acc     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    always_comb begin
        s1_diff = (ram_q > r_s1_bri) ? (ram_q - r_s1_bri) : (r_s1_bri - ram_q);
        s1_sum  = (r_s1_start ? '0 : r_sum)
                + (r_s1_cmp_take ? {{(SUM_W-BRI_W){1'b0}}, s1_diff} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmp_take <= s0_take && i_in_data.compare_frame;
            r_s1_start    <= i_in_data.frame_start;
            r_s1_last     <= s0_last;
            r_s1_emit     <= s0_last && i_in_data.compare_frame;
            r_s1_bri      <= s0_bri;
            r_s1_cnt      <= CNT_W'(c_idx + IW'(s0_take));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (s1_retire) begin
            r_sum <= r_s1_last ? '0 : s1_sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= s1_retire && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_retire && r_s1_emit) begin
            r_out.motion_sum   <= s1_sum;
            r_out.sample_count <= r_s1_cnt;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `CHK_ALWAYS(a_idx_bound, i_clk, i_rst_n, r_idx <= IDX_MAX, "sample index beyond capacity")
    `CHK_IMPLY(a_s1_blocked, i_clk, i_rst_n, r_s1_vld && r_s1_emit && r_out_vld && i_out_stall, o_in_stall, "result stage overrun while output is held")
    `CHK_NEXT(a_sum_clear, i_clk, i_rst_n, s1_retire && r_s1_last, r_sum == '0, "sum not cleared after frame end")
    `CHK_NEXT(a_cmp_read, i_clk, i_rst_n, in_acc && s0_take && i_in_data.compare_frame, r_s1_vld && r_s1_cmp_take, "compare sample lost before accumulate")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import gsfms_pkg::*;

    localparam int MAX_SAMPLES  = 128;
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_pix_in     in_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_motion_out o_out_data;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor copy of the registers and the frame state.
    logic [COORD_W-1:0] cfg_width;
    logic [COORD_W-1:0] cfg_height;
    logic [STEP_W-1:0]  grid_step;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic [8:0]         col_phase;
    logic [7:0]         row_phase;
    logic               row_parity;
    logic [CNT_W-1:0]   samp_idx;
    logic [SUM_W-1:0]   diff_sum;
    logic [BRI_W-1:0]   ref_bright [MAX_SAMPLES];
    bit                 ref_written [MAX_SAMPLES];

    t_motion_out expected_motion [$];
    int  fail_count = 0;
    int  pixels_sent = 0;
    int  results_due = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b0;
    bit  stall_on = 1'b0;

    grid_sampled_frame_motion_sum_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void clear_position();
        col_pos    = '0;
        row_pos    = '0;
        col_phase  = '0;
        row_phase  = '0;
        row_parity = 1'b0;
        samp_idx   = '0;
        diff_sum   = '0;
    endfunction

    // True when the pixel at the current position lies on the sample grid.
    function automatic bit on_grid();
        if (grid_step == 0 || row_phase != 0 || row_pos == 0) return 1'b0;
        if (int'(row_pos) + int'(grid_step) > int'(cfg_height)) return 1'b0;
        if (col_pos >= cfg_width) return 1'b0;
        if (row_parity) return int'(col_phase) == int'(grid_step);
        return col_phase == 0 && col_pos != 0;
    endfunction

    function automatic void track_pixel(input logic [15:0] pix, input bit start,
                                        input bit cmp);
        int bright;
        int stored;
        int delta;
        bit row_end;
        bit frame_end;
        t_motion_out word;
        if (start) clear_position();
        if (on_grid() && samp_idx < MAX_SAMPLES) begin
            bright = int'(pix[15:11]) + int'(pix[10:6]) + int'(pix[4:0]);
            if (cmp) begin
                stored = int'(ref_bright[samp_idx]);
                delta = (stored > bright) ? stored - bright : bright - stored;
                diff_sum = diff_sum + delta[15:0];
            end else begin
                ref_bright[samp_idx] = bright[6:0];
                ref_written[samp_idx] = 1'b1;
            end
            samp_idx = samp_idx + 8'd1;
        end
        row_end = int'(col_pos) + 1 >= int'(cfg_width);
        frame_end = row_end && int'(row_pos) + 1 >= int'(cfg_height);
        if (frame_end && cmp) begin
            word.motion_sum   = diff_sum;
            word.sample_count = samp_idx;
            expected_motion.push_back(word);
            results_due++;
        end
        if (frame_end) begin
            clear_position();
        end else if (row_end) begin
            col_pos   = '0;
            col_phase = '0;
            row_pos   = row_pos + 11'd1;
            if (int'(row_phase) + 1 >= int'(grid_step)) begin
                row_phase  = '0;
                row_parity = ~row_parity;
            end else begin
                row_phase = row_phase + 8'd1;
            end
        end else begin
            col_pos = col_pos + 11'd1;
            if (int'(col_phase) + 1 >= 2 * int'(grid_step)) col_phase = '0;
            else col_phase = col_phase + 9'd1;
        end
    endfunction

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input bit start, input bit cmp);
        int gap;
        t_pix_in word;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        // A compare point is only allowed on a slot that a reference frame has filled.
        if (cmp && !start && on_grid() && samp_idx < MAX_SAMPLES && !ref_written[samp_idx])
            cmp = 1'b0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word.pixel_rgb565  = pix;
        word.frame_start   = start;
        word.compare_frame = cmp;
        in_data  <= word;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_stall);
        track_pixel(pix, start, cmp);
        pixels_sent++;
    endtask

    task automatic send_frame(input bit cmp, input int flip_pct, input int fill);
        int npix;
        bit flag;
        logic [15:0] pix;
        npix = (cfg_width == 0 ? 1 : int'(cfg_width)) * (cfg_height == 0 ? 1 : int'(cfg_height));
        for (int i = 0; i < npix; i++) begin
            pix = (fill < 0) ? random_pixel() : fill[15:0];
            flag = ($urandom_range(0, 99) < flip_pct) ? !cmp : cmp;
            send_pixel(pix, i == 0, flag);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_motion.size() != 0);
        // The last pixel may still sit in the accumulate stage.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                              input logic [STEP_W-1:0] s);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_width = w;
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_height = h;
        cfg_idx  <= CFG_GRID_STEP;
        cfg_data <= {3'b000, s};
        @(posedge clk);
        grid_step = s;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // With a 1 x 1 frame every pixel ends a frame, so compare pixels stream
    // results and the stalled output pushes back on the input; zero sizes follow.
    task automatic test_single_pixel_frames();
        idle_on  = 1'b0;
        stall_on = 1'b1;
        set_config(11'd1, 11'd1, 8'd1);
        send_pixel(16'h0000, 1'b1, 1'b1);
        send_pixel(16'hFFFF, 1'b0, 1'b1);
        send_pixel(16'hF800, 1'b0, 1'b0);
        send_pixel(16'h07E0, 1'b1, 1'b1);
        send_pixel(16'h001F, 1'b0, 1'b1);
        send_pixel(16'h0020, 1'b0, 1'b0);
        repeat (8) send_pixel(random_pixel(), 1'($urandom_range(0, 1)), 1'b1);
        set_config(11'd0, 11'd0, 8'd0);
        repeat (4) send_pixel(random_pixel(), 1'b0, 1'($urandom_range(0, 1)));
        set_config(11'd0, 11'd3, 8'd0);
        repeat (7) send_pixel(random_pixel(), 1'b0, 1'b1);
    endtask

    task automatic test_brightness_extremes();
        idle_on  = 1'b1;
        stall_on = 1'b1;
        set_config(11'd4, 11'd4, 8'd1);
        send_frame(1'b0, 0, 16'h0000);
        send_frame(1'b1, 0, 16'hFFFF);
        send_frame(1'b0, 0, 16'hFFFF);
        send_frame(1'b1, 0, 16'h0000);
        // The lowest green bit does not count toward brightness.
        send_frame(1'b0, 0, 16'h0020);
        send_frame(1'b1, 0, 16'h0000);
        send_frame(1'b1, 0, -1);
    endtask

    // An 18 x 17 frame on a step of one holds 136 grid points, more than the
    // store takes; reference and compare pixels are mixed on both sides of
    // the limit, and the last pixel always compares.
    task automatic test_sample_capacity();
        int npix;
        bit flag;
        set_config(11'd18, 11'd17, 8'd1);
        npix = int'(cfg_width) * int'(cfg_height);
        for (int i = 0; i < npix; i++) begin
            flag = (i == npix - 1) || ($urandom_range(0, 1) == 0);
            send_pixel(random_pixel(), i == 0, flag);
        end
    endtask

    task automatic test_restart_and_mixed_flags();
        set_config(11'd5, 11'd4, 8'd1);
        send_frame(1'b0, 0, -1);
        for (int i = 0; i < 11; i++) send_pixel(random_pixel(), i == 0, 1'b1);
        send_frame(1'b1, 0, -1);
        send_frame(1'b1, 50, -1);
        send_frame(1'b0, 50, -1);
    endtask

    task automatic test_config_mid_frame();
        set_config(11'd6, 11'd6, 8'd2);
        send_frame(1'b0, 0, -1);
        for (int i = 0; i < 20; i++) send_pixel(random_pixel(), i == 0, 1'b1);
        set_config(11'd5, 11'd8, 8'd2);
        repeat (50) send_pixel(random_pixel(), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    // The largest register values, then a shrink in the middle of the frame
    // so that the oversized position and phases wrap.
    task automatic test_largest_sizes();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        set_config(11'd2047, 11'd2047, 8'd255);
        for (int i = 0; i < 20; i++) send_pixel(random_pixel(), i == 0, 1'b1);
        set_config(11'd3, 11'd2, 8'd1);
        repeat (8) send_pixel(random_pixel(), 1'b0, 1'b1);
    endtask

    // Mostly reference/compare pairs on small random grids, with some cut
    // frames and loose pixels mixed in.
    task automatic test_random_frames();
        int first_pixel;
        int first_result;
        int npix;
        int cut;
        logic [STEP_W-1:0] s;
        first_pixel  = pixels_sent;
        first_result = results_due;
        while (pixels_sent - first_pixel < 100 || results_due - first_result < 8) begin
            idle_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            s = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
            set_config(11'($urandom_range(1, 8)), 11'($urandom_range(1, 8)), s);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0: begin
                        npix = int'(cfg_width) * int'(cfg_height);
                        cut = (npix > 1) ? $urandom_range(1, npix - 1) : 1;
                        for (int i = 0; i < cut; i++)
                            send_pixel(random_pixel(), i == 0, 1'($urandom_range(0, 1)));
                    end
                    1: begin
                        repeat (5) send_pixel(random_pixel(), $urandom_range(0, 3) == 0,
                                              1'($urandom_range(0, 1)));
                    end
                    default: begin
                        send_frame(1'b0, 0, -1);
                        send_frame(1'b1, ($urandom_range(0, 2) == 0) ? 10 : 0, -1);
                    end
                endcase
            end
        end
    endtask

    // Output side: while stall_on is set, stall each word for a random number of its valid cycles.
    always @(posedge clk) begin
        t_motion_out want;
        if (rst_n && o_out_valid) begin
            if (!out_stall) begin
                if (expected_motion.size() == 0) begin
                    report_mismatch($sformatf("unexpected word sum %0d count %0d",
                                              o_out_data.motion_sum,
                                              o_out_data.sample_count));
                end else begin
                    want = expected_motion.pop_front();
                    if (o_out_data.motion_sum !== want.motion_sum)
                        report_mismatch($sformatf("motion_sum %0d, expected %0d",
                                                  o_out_data.motion_sum, want.motion_sum));
                    if (o_out_data.sample_count !== want.sample_count)
                        report_mismatch($sformatf("sample_count %0d, expected %0d",
                                                  o_out_data.sample_count,
                                                  want.sample_count));
                end
                stall_left = stall_on ? $urandom_range(0, 9) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        cfg_width  = WIDTH_RST;
        cfg_height = HEIGHT_RST;
        grid_step  = STEP_RST;
        clear_position();
        foreach (ref_written[i]) ref_written[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_pixel_frames();
        test_brightness_extremes();
        test_sample_capacity();
        test_restart_and_mixed_flags();
        test_config_mid_frame();
        test_largest_sizes();
        test_random_frames();
        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== grid_sampled_frame_motion_sum_core.f =====
+incdir+rtl/core
rtl/core/gsfms_pkg.sv
rtl/core/gsfms_ram.sv
rtl/core/grid_sampled_frame_motion_sum_core.sv
tb/sv/testbench.sv
